[src/ubr_pkg.sv]
// ----------------------------------------------------------------------------
// ubr_pkg
// Shared types and constants of the ultrasonic burst and echo ranger.
// ----------------------------------------------------------------------------
package ubr_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_CLAMP,
        ST_PUSH
    } ubr_state_t;

    // Measurement phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_BLANK,
        PH_LISTEN
    } ubr_phase_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_DISTANCE_GAIN = 3'd0;
    localparam logic [2:0] CFG_BLANK_TICKS   = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd2;
    localparam logic [2:0] CFG_EDGES_NEEDED  = 3'd3;
    localparam logic [2:0] CFG_MIN_DISTANCE  = 3'd4;
    localparam logic [2:0] CFG_MAX_DISTANCE  = 3'd5;
    localparam logic [2:0] CFG_NO_ECHO_VALUE = 3'd6;

    // Register values after reset
    localparam logic [15:0] GAIN_RST     = 16'd256;
    localparam logic [9:0]  BLANK_RST    = 10'd59;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1200;
    localparam logic [3:0]  EDGES_RST    = 4'd7;
    localparam logic [7:0]  MIN_DIST_RST = 8'd20;
    localparam logic [7:0]  MAX_DIST_RST = 8'd240;
    localparam logic [7:0]  NO_ECHO_RST  = 8'd250;

    // Half distance = floor(ticks * 17 / 100)
    localparam int unsigned TICK_MUL = 17;
    localparam logic [7:0]  TICK_DIV = 8'd100;

    // Controller to datapath
    typedef struct packed {
        logic step;
        logic div_start;
        logic mul_load;
        logic clamp_load;
        logic push;
    } ubr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic calc;
        logic div_done;
        logic out_free;
    } ubr_sts_t;

endpackage

[src/ubr_div.sv]
// ----------------------------------------------------------------------------
// ubr_div
// Divider by the constant 100 using a reciprocal multiplication: the dividend
// is captured, then multiplied by the scaled reciprocal.
// ----------------------------------------------------------------------------
module ubr_div
    import ubr_pkg::*;
#(
    parameter int W = 21
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic         done,
    output logic [W-1:0] quotient
);

    // floor(n / 100) = (n * RECIP) >> SH for every n below 2^W
    localparam int SH = W + 7;
    localparam int RW = W + 1;
    localparam int PW = W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(TICK_DIV) - 64'd1) / 64'(TICK_DIV));

    logic [W-1:0]  arg_reg;
    logic [PW-1:0] prod_reg;
    logic          run_reg;
    logic          done_reg;

    // Handshake: capture cycle, then product cycle, then done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= start;
            done_reg <= run_reg;
        end
    end

    // Operand capture and reciprocal product
    always_ff @(posedge aclk) begin
        if (start) begin
            arg_reg <= dividend;
        end
        if (run_reg) begin
            prod_reg <= PW'(arg_reg) * PW'(RECIP);
        end
    end

    assign done     = done_reg;
    assign quotient = W'(prod_reg[PW-1:SH]);

endmodule

[src/ubr_ctrl.sv]
// ----------------------------------------------------------------------------
// ubr_ctrl
// Sequencer: takes a tick, runs the distance arithmetic when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ubr_ctrl
    import ubr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ubr_sts_t sts,
    output ubr_cmd_t cmd
);

    ubr_state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.calc ? ST_DIVGO : ST_PUSH;
                end
            end
            ST_DIVGO: begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (sts.div_done) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
            end
            ST_DIVGO: begin
                cmd.div_start = 1'b1;
            end
            ST_DIVWAIT: begin
                cmd.mul_load = sts.div_done;
            end
            ST_CLAMP: begin
                cmd.clamp_load = 1'b1;
            end
            ST_PUSH: begin
                cmd.push = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/ubr_datapath.sv]
// ----------------------------------------------------------------------------
// ubr_datapath
// Measurement state, configuration registers, distance arithmetic and the
// result and output registers.
// ----------------------------------------------------------------------------
module ubr_datapath
    import ubr_pkg::*;
#(
    parameter int CHANNELS           = 6,
    parameter int BURST_HALF_PERIODS = 16,
    parameter int TICK_WIDTH         = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ubr_cmd_t    cmd,
    output ubr_sts_t    sts,
    input  logic [7:0]  s_tdata,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int TW = TICK_WIDTH;
    localparam int W  = TW + 5;                  // holds ticks * 17
    localparam int LW = (TW > 17 ? TW : 17) + 1; // compare width for limits
    localparam int PW = W + 16;                  // product width

    // Input fields
    logic       in_start, in_send, in_count, in_echo;
    logic [2:0] in_chan;

    assign in_start = s_tdata[0];
    assign in_chan  = s_tdata[3:1];
    assign in_send  = s_tdata[4];
    assign in_count = s_tdata[5];
    assign in_echo  = s_tdata[6];

    // Configuration registers
    logic [15:0] gain_reg;
    logic [9:0]  blank_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  edges_reg;
    logic [7:0]  min_reg, max_reg, no_echo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RST;
            blank_reg   <= BLANK_RST;
            timeout_reg <= TIMEOUT_RST;
            edges_reg   <= EDGES_RST;
            min_reg     <= MIN_DIST_RST;
            max_reg     <= MAX_DIST_RST;
            no_echo_reg <= NO_ECHO_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DISTANCE_GAIN: gain_reg    <= cfg_data;
                CFG_BLANK_TICKS:   blank_reg   <= cfg_data[9:0];
                CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                CFG_EDGES_NEEDED:  edges_reg   <= cfg_data[3:0];
                CFG_MIN_DISTANCE:  min_reg     <= cfg_data[7:0];
                CFG_MAX_DISTANCE:  max_reg     <= cfg_data[7:0];
                CFG_NO_ECHO_VALUE: no_echo_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Measurement state
    ubr_phase_t    phase_reg, phase_next;
    logic [2:0]    chan_reg,  chan_next;
    logic [4:0]    hp_reg,    hp_next;
    logic [TW-1:0] ft_reg,    ft_next;
    logic [3:0]    ec_reg,    ec_next;

    logic          done_c, tmo_c, calc_c;
    logic [TW-1:0] snap_c;
    logic [3:0]    need;
    logic [LW-1:0] limit;

    assign need  = (edges_reg == 4'd0) ? 4'd1 : edges_reg;
    assign limit = LW'(blank_reg) + LW'(timeout_reg);

    // One tick: start, burst strobe, count strobe, blanking end, echo, timeout
    always_comb begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        hp_next    = hp_reg;
        ft_next    = ft_reg;
        ec_next    = ec_reg;
        done_c     = 1'b0;
        tmo_c      = 1'b0;
        calc_c     = 1'b0;
        snap_c     = ft_reg;

        if (in_start && phase_next == PH_IDLE && ({1'b0, in_chan} < 4'(CHANNELS))) begin
            chan_next  = in_chan;
            phase_next = PH_SEND;
            hp_next    = '0;
            ft_next    = '0;
            ec_next    = '0;
        end

        if (in_send && phase_next == PH_SEND) begin
            if (hp_next != 5'(BURST_HALF_PERIODS)) begin
                hp_next = hp_next + 5'd1;
            end else begin
                hp_next    = '0;
                phase_next = PH_BLANK;
            end
        end

        if (in_count && (phase_next == PH_BLANK || phase_next == PH_LISTEN)) begin
            if (ft_next != {TW{1'b1}}) begin
                ft_next = ft_next + TW'(1);
            end
        end

        if (phase_next == PH_BLANK && LW'(ft_next) >= LW'(blank_reg)) begin
            phase_next = PH_LISTEN;
        end

        if (phase_next == PH_LISTEN && in_echo) begin
            ec_next = ec_next + 4'd1;
            if (ec_next >= need) begin
                done_c     = 1'b1;
                calc_c     = 1'b1;
                snap_c     = ft_next;
                phase_next = PH_IDLE;
                hp_next    = '0;
                ft_next    = '0;
                ec_next    = '0;
            end
        end

        if (phase_next == PH_LISTEN) begin
            if (LW'(ft_next) >= limit || ft_next == {TW{1'b1}}) begin
                done_c     = 1'b1;
                tmo_c      = 1'b1;
                phase_next = PH_IDLE;
                hp_next    = '0;
                ft_next    = '0;
                ec_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            chan_reg  <= '0;
            hp_reg    <= '0;
            ft_reg    <= '0;
            ec_reg    <= '0;
        end else if (cmd.step) begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            hp_reg    <= hp_next;
            ft_reg    <= ft_next;
            ec_reg    <= ec_next;
        end
    end

    // Pending result of the last tick
    logic          res_tx, res_busy, res_done, res_tmo;
    logic [2:0]    res_chan;
    logic [7:0]    res_dist;
    logic [TW-1:0] snap_reg;

    // Distance arithmetic: ticks * 17, divide by 100, gain, clamp
    logic [W-1:0]  dividend, quot;
    logic          div_done;
    logic [PW-1:0] prod_reg;
    logic [W+7:0]  scaled, lo_clamped;
    logic [7:0]    dist_c;

    assign dividend = (W'(snap_reg) << 4) + W'(snap_reg);

    ubr_div #(
        .W (W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb begin
        scaled     = prod_reg[PW-1:8];
        lo_clamped = (scaled < (W+8)'(min_reg)) ? (W+8)'(min_reg) : scaled;
        dist_c     = (lo_clamped > (W+8)'(max_reg)) ? max_reg : lo_clamped[7:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            res_tx   <= !(phase_next == PH_SEND && hp_next[0]);
            res_chan <= chan_next;
            res_busy <= (phase_next != PH_IDLE);
            res_done <= done_c;
            res_tmo  <= tmo_c;
            res_dist <= tmo_c ? no_echo_reg : 8'd0;
            snap_reg <= snap_c;
        end else if (cmd.clamp_load) begin
            res_dist <= dist_c;
        end
        if (cmd.mul_load) begin
            prod_reg <= PW'(quot) * PW'(gain_reg);
        end
    end

    // Output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic [1:0]  m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg <= {3'b000, res_dist, res_busy, res_chan, res_tx};
            m_user_reg <= {res_tmo, res_done};
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign m_tuser      = m_user_reg;

    assign sts.calc     = calc_c;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_tready;

endmodule

[src/ultrasonic_burst_echo_ranger_top.sv]
// ----------------------------------------------------------------------------
// ultrasonic_burst_echo_ranger_top
// Ultrasonic burst-and-echo ranger: one tick per input transaction, one
// status and result transaction per tick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                         Carries
//  s_       in         s_tvalid s_tready s_tdata[7:0]  one tick of strobes
//  m_       out        m_tvalid m_tready m_tdata[15:0] line, status, distance
//                      m_tuser[1:0]                    done and timeout flags
//  cfg_     in         cfg_valid cfg_ready cfg_index   register writes
//                      cfg_data[15:0]
//
//  A tick is accepted, then its result is moved into the output register. A
//  tick that completes a measurement on an echo goes through accept, divide
//  start, the reciprocal divide by 100 and the gain multiply, clamp, and the
//  move into the output register.
//  aresetn is synchronous and active low; the configuration, state and valid registers return to their defaults.
//  The next tick is taken while a result waits in the output register; a
//  stalled m_ side holds the following result in the pending stage.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ultrasonic_burst_echo_ranger_top
    import ubr_pkg::*;
#(
    parameter int CHANNELS           = 6,
    parameter int BURST_HALF_PERIODS = 16,
    parameter int TICK_WIDTH         = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_req[0], channel[3:1], send_tick[4], count_tick[5], echo_fall[6]
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_level[0], tx_channel[3:1], busy_res[4], distance[12:5]
    output logic [15:0] m_tdata,
    // done_res[0], timed_out[1]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ubr_cmd_t cmd;
    ubr_sts_t sts;

    assign cfg_ready = 1'b1;

    ubr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ubr_datapath #(
        .CHANNELS           (CHANNELS),
        .BURST_HALF_PERIODS (BURST_HALF_PERIODS),
        .TICK_WIDTH         (TICK_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[src/ubr_checker.sv]
// ----------------------------------------------------------------------------
// ubr_checker
// Port-level checks of the ranger, bound to the top level.
// ----------------------------------------------------------------------------
module ubr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Timeout only comes with done
    a_tmo_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("timeout flag without done");

    // A finished measurement leaves the block idle, and idle drives the line high
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[4] && m_tdata[0])
        else $error("busy or line low on a finished measurement");

    // Distance is zero unless a result is reported
    a_dist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[12:5] == 8'd0)
        else $error("distance without done");

endmodule

bind ultrasonic_burst_echo_ranger_top ubr_checker u_ubr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
